/* rtl/core/helix_step_uniform_field_core_macros.svh */
// ----------------------------------------------------------------------------
// Helix step core - assertion macros
// Implication checks on a clock, with reset masking.
// ----------------------------------------------------------------------------
`ifndef HELIX_STEP_UNIFORM_FIELD_CORE_MACROS_SVH
`define HELIX_STEP_UNIFORM_FIELD_CORE_MACROS_SVH

// same-cycle implication
`define HSUF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsuf same-cycle check failed");

// next-cycle implication
`define HSUF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsuf next-cycle check failed");

`endif

/* rtl/core/hsuf_pkg.sv */
// ----------------------------------------------------------------------------
// Helix step core - package
// Beat types, fixed-point constants, rounding and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsuf_pkg;

  localparam int POS_W   = 32;
  localparam int DIR_W   = 18;
  localparam int MOM_W   = 32;
  localparam int FIELD_W = 20;

  localparam logic [FIELD_W-1:0] FIELD_RESET = 20'd55565;

  localparam int LIGHT_W = 29;
  localparam logic [LIGHT_W-1:0] LIGHT_NUM = 29'd299792458;

  // 1e11 = 1e5 * 1e6, split into its low 20 and high 17 bits for two narrow products
  localparam longint unsigned DEN_SCALE = 64'd100000000000;
  localparam int DEN_LO_W = 20;
  localparam int DEN_HI_W = 17;
  localparam logic [DEN_LO_W-1:0] DEN_LO = DEN_LO_W'(DEN_SCALE % (64'd1 << DEN_LO_W));
  localparam logic [DEN_HI_W-1:0] DEN_HI = DEN_HI_W'(DEN_SCALE >> DEN_LO_W);
  localparam int DEN_W = MOM_W + DEN_LO_W + DEN_HI_W;

  localparam int Q    = 30;
  localparam int T_W  = 31;
  localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam int SC_W = 32;

  localparam int A_W     = 64;
  localparam int SMALL_W = 27;
  localparam logic [A_W-1:0] SMALL_LIM = 64'd1 << SMALL_W;
  localparam logic [31:0] PI_HALF_Q30 = 32'h6487ED51;
  localparam logic [63:0] TWO_OVER_PI = 64'hA2F9836E4E441529;

  localparam int HORNER_N = 5;
  localparam int unsigned SIN_K  [HORNER_N] = '{110, 72, 42, 20, 6};
  localparam int unsigned VERS_K [HORNER_N] = '{132, 90, 56, 30, 12};

  localparam int Q2_W  = 35;
  localparam int G_W   = 36;
  localparam int MX_W  = 34;
  localparam int RND_M = 17;
  localparam int RND_P = 13;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_z;
    logic [DIR_W-1:0] dir_x;
    logic [DIR_W-1:0] dir_z;
    logic [MOM_W-1:0] momentum;
    logic [POS_W-1:0] step_length;
  } in_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x_out;
    logic [POS_W-1:0] pos_z_out;
    logic [DIR_W-1:0] dir_x_out;
    logic [DIR_W-1:0] dir_z_out;
    logic [MOM_W-1:0] momentum_out;
    logic             bad_momentum;
  } out_beat_t;

  typedef struct packed {
    in_beat_t beat;
    logic     bad;
    logic     neg;
  } ctx_t;

  // round half away from zero
  function automatic logic signed [63:0] rnd_half(input logic signed [63:0] v,
                                                  input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [63:0] v);
    logic [POS_W-1:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DIR_W-1:0] sat_dir(input logic signed [63:0] v);
    logic [DIR_W-1:0] r;
    if (v > 64'sh1FFFF) begin
      r = 18'h1FFFF;
    end else if (v < -64'sh20000) begin
      r = 18'h20000;
    end else begin
      r = v[DIR_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/hsuf_div_cell.sv */
// ----------------------------------------------------------------------------
// Helix step core - divider cell
// One restoring quotient bit per cell; quotient shifts in as numerator leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsuf_div_cell #(
  parameter int DW = 64,
  parameter int QW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o
);

  logic [DW:0] part;
  logic [DW:0] diff;
  logic        ge;

  assign part = {rem_i, quo_i[QW-1]};
  assign diff = part - {1'b0, den_i};
  assign ge   = part >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[DW-1:0] : part[DW-1:0];
      den_o <= den_i;
      quo_o <= {quo_i[QW-2:0], ge};
    end
  end

endmodule

/* rtl/core/hsuf_horner_cell.sv */
// ----------------------------------------------------------------------------
// Helix step core - series cell
// One Horner step t' = 1 - (x2*t)/K in Q30, over two registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsuf_horner_cell #(
  parameter int unsigned K = 6
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [hsuf_pkg::T_W-1:0] x2_i,
  input  logic [hsuf_pkg::T_W-1:0] t_i,
  output logic [hsuf_pkg::T_W-1:0] t_o
);

  import hsuf_pkg::*;

  // exact floor(hi/K) by reciprocal multiplication over the full width of hi
  localparam int RW = 2*T_W-Q;
  localparam int L  = $clog2(K);
  localparam longint unsigned RECIP = ((64'd1 << (RW + L)) + 64'(K) - 64'd1) / 64'(K);

  logic [2*T_W-1:0]   prod;
  logic [2*T_W-Q-1:0] hi;
  logic [2*RW:0]      qp;

  assign hi = prod[2*T_W-1:Q];
  assign qp = (2*RW+1)'(hi) * (2*RW+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (2*T_W)'(x2_i) * (2*T_W)'(t_i);
      t_o  <= ONE_Q30 - T_W'(qp[2*RW:RW+L]);
    end
  end

endmodule

/* rtl/core/helix_step_uniform_field_core.sv */
// ----------------------------------------------------------------------------
// Helix step core - top level
// Moves a track along a circular arc in a uniform field, one beat per cycle unless a held result stalls it.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------
//  in       | in_valid / in_stall      | in_data  (in_beat_t)
//  out      | out_valid / out_stall    | out_data (out_beat_t)
//  cfg      | cfg_wr_en                | cfg_wr_data (field, Q4.16)
//
//  One beat per cycle while no held result stalls the chain; the depth is set mostly
//  by the 64-cell angle divider and the 35-cell sinc divider.
//  Synchronous reset clears the valid chain and loads the default field.
//  A held result freezes the whole cell chain; in_stall follows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "helix_step_uniform_field_core_macros.svh"

module helix_step_uniform_field_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [hsuf_pkg::FIELD_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  hsuf_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output hsuf_pkg::out_beat_t          out_data
);

  import hsuf_pkg::*;

  localparam int M1_W  = FIELD_W + POS_W;
  localparam int M1_LO = 26;
  localparam int N_W   = M1_W + LIGHT_W;
  localparam int NF_W  = N_W + Q - FRAC_BITS;
  localparam int PW    = G_W + DIR_W;
  localparam int PS_W  = SC_W + DIR_W;

  localparam int K_D1 = 3;
  localparam int K_T1 = K_D1 + A_W;
  localparam int K_T4 = K_T1 + 3;
  localparam int K_E1 = K_T4 + 2 * HORNER_N + 1;
  localparam int K_E2 = K_E1 + 1;
  localparam int K_F1 = K_E2 + Q2_W + 1;
  localparam int LAT  = K_F1 + 5;

  typedef struct packed {
    logic           tiny;
    logic [2:0]     oct;
    logic [A_W-1:0] a;
    logic [T_W-1:0] x;
    logic [T_W-1:0] x2;
  } trig_t;

  typedef struct packed {
    logic            tiny;
    logic [T_W-1:0]  hs;
    logic [T_W-1:0]  w;
    logic [SC_W-1:0] sa;
    logic [SC_W-1:0] ca;
  } coef_t;

  logic               en;
  logic [LAT-1:0]     vld;
  ctx_t               ctx [LAT];
  ctx_t               in_ctx;
  logic [FIELD_W-1:0] field;

  always_ff @(posedge clk) begin
    if (rst) begin
      field <= FIELD_RESET;
    end else if (cfg_wr_en) begin
      field <= cfg_wr_data;
    end
  end

  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign in_ctx.beat = in_data;
  assign in_ctx.bad  = in_data.momentum == '0;
  assign in_ctx.neg  = field[FIELD_W-1] == in_data.step_length[POS_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0] <= in_ctx;
      for (int k = 1; k < LAT; k++) begin
        ctx[k] <= ctx[k-1];
      end
    end
  end

  // angle numerator and denominator
  logic [FIELD_W-1:0]           b_abs;
  logic [POS_W-1:0]             st_abs;
  logic [M1_W-1:0]              m1;
  logic [MOM_W+DEN_LO_W-1:0]    dp_lo;
  logic [MOM_W+DEN_HI_W-1:0]    dp_hi;
  logic [M1_LO+LIGHT_W-1:0]     n_lo;
  logic [M1_W-M1_LO+LIGHT_W-1:0] n_hi;
  logic [DEN_W-1:0]             den;
  logic [N_W-1:0]               nsum;
  logic [NF_W-1:0]              nf;

  assign b_abs  = field[FIELD_W-1] ? FIELD_W'(-field) : field;
  assign st_abs = in_data.step_length[POS_W-1] ? POS_W'(-in_data.step_length)
                                               : in_data.step_length;
  assign nsum   = (N_W'(n_hi) << M1_LO) + N_W'(n_lo);
  assign nf     = NF_W'(nsum) << (Q - FRAC_BITS);

  localparam int Q1_LEN = A_W + 1;
  logic [DEN_W-1:0] d1_rem [Q1_LEN];
  logic [DEN_W-1:0] d1_den [Q1_LEN];
  logic [A_W-1:0]   d1_quo [Q1_LEN];

  always_ff @(posedge clk) begin
    if (en) begin
      m1        <= M1_W'(b_abs) * M1_W'(st_abs);
      dp_lo     <= (MOM_W+DEN_LO_W)'(in_data.momentum) * (MOM_W+DEN_LO_W)'(DEN_LO);
      dp_hi     <= (MOM_W+DEN_HI_W)'(in_data.momentum) * (MOM_W+DEN_HI_W)'(DEN_HI);
      n_lo      <= (M1_LO+LIGHT_W)'(m1[M1_LO-1:0]) * (M1_LO+LIGHT_W)'(LIGHT_NUM);
      n_hi      <= (M1_W-M1_LO+LIGHT_W)'(m1[M1_W-1:M1_LO])
                   * (M1_W-M1_LO+LIGHT_W)'(LIGHT_NUM);
      den       <= (DEN_W'(dp_hi) << DEN_LO_W) + DEN_W'(dp_lo);
      d1_rem[0] <= DEN_W'(nf >> A_W);
      d1_quo[0] <= nf[A_W-1:0];
      d1_den[0] <= den;
    end
  end

  for (genvar j = 0; j < A_W; j++) begin : g_div1
    hsuf_div_cell #(.DW(DEN_W), .QW(A_W)) u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (d1_rem[j]),
      .den_i (d1_den[j]),
      .quo_i (d1_quo[j]),
      .rem_o (d1_rem[j+1]),
      .den_o (d1_den[j+1]),
      .quo_o (d1_quo[j+1])
    );
  end

  // angle to phase, octant fold, first argument
  logic [A_W-1:0]   a;
  logic [63:0]      pp_ll, pp_lh, pp_hl, pp_hh;
  logic [A_W-1:0]   a_t1, a_t2, a_t3;
  logic             sm_t1, sm_t2, sm_t3;
  logic [95:0]      sum96;
  logic [31:0]      turn;
  logic [2:0]       oct_t3;
  logic [T_W-1:0]   x_t3;
  logic [29:0]      r_fold;
  logic [61:0]      x_prod;
  logic [61:0]      sq_prod;

  assign a     = d1_quo[A_W];
  assign sum96 = (96'(pp_hh) << 64) + (96'(pp_lh) << 32) + (96'(pp_hl) << 32)
               + 96'(pp_ll);
  assign r_fold = turn[29] ? (30'h2000_0000 - {1'b0, turn[28:0]}) : {1'b0, turn[28:0]};
  assign x_prod  = 62'(r_fold) * 62'(PI_HALF_Q30);
  assign sq_prod = 62'(x_t3) * 62'(x_t3);

  trig_t tr [2*HORNER_N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll  <= 64'(a[31:0])  * 64'(TWO_OVER_PI[31:0]);
      pp_lh  <= 64'(a[31:0])  * 64'(TWO_OVER_PI[63:32]);
      pp_hl  <= 64'(a[63:32]) * 64'(TWO_OVER_PI[31:0]);
      pp_hh  <= 64'(a[63:32]) * 64'(TWO_OVER_PI[63:32]);
      a_t1   <= a;
      sm_t1  <= a < SMALL_LIM;
      turn   <= sum96[95:64];
      a_t2   <= a_t1;
      sm_t2  <= sm_t1;
      x_t3   <= sm_t2 ? T_W'(a_t2[SMALL_W-1:0]) : T_W'(x_prod[61:Q]);
      oct_t3 <= turn[31:29];
      a_t3   <= a_t2;
      sm_t3  <= sm_t2;
      tr[0].tiny  <= sm_t3;
      tr[0].oct   <= oct_t3;
      tr[0].a     <= a_t3;
      tr[0].x     <= x_t3;
      tr[0].x2    <= sq_prod[Q+T_W-1:Q];
      for (int m = 1; m <= 2 * HORNER_N; m++) begin
        tr[m] <= tr[m-1];
      end
    end
  end

  // series in x2 for sin(x)/x and (1-cos x)/(x2/2)
  logic [T_W-1:0] hs [HORNER_N+1];
  logic [T_W-1:0] hv [HORNER_N+1];

  assign hs[0] = ONE_Q30;
  assign hv[0] = ONE_Q30;

  for (genvar j = 0; j < HORNER_N; j++) begin : g_horner
    hsuf_horner_cell #(.K(SIN_K[j])) u_sin (
      .clk  (clk),
      .en   (en),
      .x2_i (tr[2*j].x2),
      .t_i  (hs[j]),
      .t_o  (hs[j+1])
    );
    hsuf_horner_cell #(.K(VERS_K[j])) u_vers (
      .clk  (clk),
      .en   (en),
      .x2_i (tr[2*j].x2),
      .t_i  (hv[j]),
      .t_o  (hv[j+1])
    );
  end

  // sin, cos, small-turn coefficients; sinc and versine divider set-up
  trig_t                tl;
  logic [2*T_W-1:0]     s_prod, v_prod, w_prod;
  logic [T_W-1:0]       s_e1, v_e1, w_e1, hs_e1;
  logic [A_W-1:0]       a_e1;
  logic [2:0]           oct_e1;
  logic                 sm_e1;
  logic signed [SC_W-1:0] sv, cv, s_sel, c_sel, sa_e, ca_e;
  logic signed [SC_W:0]   one_m;
  logic                 swap, sneg, cneg;
  logic [61:0]          n1, n2;

  assign tl     = tr[2*HORNER_N];
  assign s_prod = (2*T_W)'(tl.x)  * (2*T_W)'(hs[HORNER_N]);
  assign v_prod = (2*T_W)'(tl.x2) * (2*T_W)'(hv[HORNER_N]);
  assign w_prod = (2*T_W)'(tl.x)  * (2*T_W)'(hv[HORNER_N]);

  assign sv    = $signed(SC_W'(s_e1));
  assign cv    = $signed(SC_W'(ONE_Q30)) - $signed(SC_W'(v_e1));
  assign swap  = !sm_e1 && (oct_e1[0] ^ oct_e1[1]);
  assign sneg  = !sm_e1 && oct_e1[2];
  assign cneg  = !sm_e1 && (oct_e1[1] ^ oct_e1[2]);
  assign s_sel = swap ? cv : sv;
  assign c_sel = swap ? sv : cv;
  assign sa_e  = sneg ? -s_sel : s_sel;
  assign ca_e  = cneg ? -c_sel : c_sel;
  assign one_m = $signed((SC_W+1)'(ONE_Q30)) - (SC_W+1)'(ca_e);
  assign n1    = 62'(s_sel[SC_W-2:0]) << Q;
  assign n2    = 62'(one_m[SC_W-1:0]) << Q;

  logic [A_W-1:0]  d2a_rem [Q2_W+1];
  logic [A_W-1:0]  d2a_den [Q2_W+1];
  logic [Q2_W-1:0] d2a_quo [Q2_W+1];
  logic [A_W-1:0]  d2b_rem [Q2_W+1];
  logic [A_W-1:0]  d2b_den [Q2_W+1];
  logic [Q2_W-1:0] d2b_quo [Q2_W+1];
  coef_t           cf [Q2_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      s_e1   <= s_prod[Q+T_W-1:Q];
      v_e1   <= v_prod[Q+T_W:Q+1];
      w_e1   <= w_prod[Q+T_W:Q+1];
      hs_e1  <= hs[HORNER_N];
      a_e1   <= tl.a;
      oct_e1 <= tl.oct;
      sm_e1  <= tl.tiny;
      d2a_rem[0] <= A_W'(n1 >> Q2_W);
      d2a_quo[0] <= n1[Q2_W-1:0];
      d2a_den[0] <= a_e1;
      d2b_rem[0] <= A_W'(n2 >> Q2_W);
      d2b_quo[0] <= n2[Q2_W-1:0];
      d2b_den[0] <= a_e1;
      cf[0].tiny  <= sm_e1;
      cf[0].hs    <= hs_e1;
      cf[0].w     <= w_e1;
      cf[0].sa    <= sa_e;
      cf[0].ca    <= ca_e;
      for (int m = 1; m <= Q2_W; m++) begin
        cf[m] <= cf[m-1];
      end
    end
  end

  for (genvar j = 0; j < Q2_W; j++) begin : g_div2
    hsuf_div_cell #(.DW(A_W), .QW(Q2_W)) u_sinc (
      .clk   (clk),
      .en    (en),
      .rem_i (d2a_rem[j]),
      .den_i (d2a_den[j]),
      .quo_i (d2a_quo[j]),
      .rem_o (d2a_rem[j+1]),
      .den_o (d2a_den[j+1]),
      .quo_o (d2a_quo[j+1])
    );
    hsuf_div_cell #(.DW(A_W), .QW(Q2_W)) u_vers (
      .clk   (clk),
      .en    (en),
      .rem_i (d2b_rem[j]),
      .den_i (d2b_den[j]),
      .quo_i (d2b_quo[j]),
      .rem_o (d2b_rem[j+1]),
      .den_o (d2b_den[j+1]),
      .quo_o (d2b_quo[j+1])
    );
  end

  // arc update
  coef_t                  cl;
  ctx_t                   c_f1, c_f2, c_f3, c_f4;
  logic signed [G_W-1:0]  g1_raw, g2_raw, g1, g2;
  logic signed [SC_W-1:0] sa_f, ca_f;
  logic signed [PW-1:0]   p_g1dx, p_g2dz, p_g1dz, p_g2dx;
  logic signed [PS_W-1:0] p_cdx, p_sdz, p_cdz, p_sdx;
  logic signed [MX_W-1:0] mx, mz;
  logic [DIR_W-1:0]       ndx, ndz, ndx_f4, ndz_f4;
  logic signed [63:0]     pmx, pmz;
  logic signed [DIR_W-1:0] dx_f2, dz_f2;
  logic signed [63:0]     rx, rz;
  out_beat_t              res;

  assign cl     = cf[Q2_W];
  assign c_f1   = ctx[K_F1-1];
  assign c_f2   = ctx[K_F1];
  assign c_f3   = ctx[K_F1+2];
  assign c_f4   = ctx[K_F1+3];
  assign dx_f2  = $signed(c_f2.beat.dir_x);
  assign dz_f2  = $signed(c_f2.beat.dir_z);
  assign g1_raw = cl.tiny ? $signed(G_W'(cl.hs))
                : (cl.sa[SC_W-1] ? -$signed(G_W'(d2a_quo[Q2_W]))
                                 : $signed(G_W'(d2a_quo[Q2_W])));
  assign g2_raw = cl.tiny ? $signed(G_W'(cl.w)) : $signed(G_W'(d2b_quo[Q2_W]));
  assign rx     = rnd_half(pmx, FRAC_BITS + RND_P);
  assign rz     = rnd_half(pmz, FRAC_BITS + RND_P);

  always_comb begin
    res.momentum_out = c_f4.beat.momentum;
    res.bad_momentum = c_f4.bad;
    if (c_f4.bad) begin
      res.pos_x_out = c_f4.beat.pos_x;
      res.pos_z_out = c_f4.beat.pos_z;
      res.dir_x_out = c_f4.beat.dir_x;
      res.dir_z_out = c_f4.beat.dir_z;
    end else begin
      res.pos_x_out = sat_pos(64'($signed(c_f4.beat.pos_x)) + rx);
      res.pos_z_out = sat_pos(64'($signed(c_f4.beat.pos_z)) + rz);
      res.dir_x_out = ndx_f4;
      res.dir_z_out = ndz_f4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1     <= g1_raw;
      g2     <= c_f1.neg ? -g2_raw : g2_raw;
      sa_f   <= c_f1.neg ? -$signed(cl.sa) : $signed(cl.sa);
      ca_f   <= $signed(cl.ca);
      p_g1dx <= PW'(g1) * PW'(dx_f2);
      p_g2dz <= PW'(g2) * PW'(dz_f2);
      p_g1dz <= PW'(g1) * PW'(dz_f2);
      p_g2dx <= PW'(g2) * PW'(dx_f2);
      p_cdx  <= PS_W'(ca_f) * PS_W'(dx_f2);
      p_sdz  <= PS_W'(sa_f) * PS_W'(dz_f2);
      p_cdz  <= PS_W'(ca_f) * PS_W'(dz_f2);
      p_sdx  <= PS_W'(sa_f) * PS_W'(dx_f2);
      mx     <= MX_W'(rnd_half(64'(p_g1dx) + 64'(p_g2dz), RND_M));
      mz     <= MX_W'(rnd_half(64'(p_g1dz) - 64'(p_g2dx), RND_M));
      ndx    <= sat_dir(rnd_half(64'(p_cdx) + 64'(p_sdz), Q));
      ndz    <= sat_dir(rnd_half(64'(p_cdz) - 64'(p_sdx), Q));
      pmx    <= 64'($signed(c_f3.beat.step_length)) * 64'(mx);
      pmz    <= 64'($signed(c_f3.beat.step_length)) * 64'(mz);
      ndx_f4 <= ndx;
      ndz_f4 <= ndz;
      out_data <= res;
    end
  end

  assign out_valid = vld[LAT-1];

  `HSUF_ASSERT_SAME(a_bad_zero_mom, clk, rst, out_valid && out_data.bad_momentum, out_data.momentum_out == '0)
  `HSUF_ASSERT_SAME(a_good_mom, clk, rst, out_valid && !out_data.bad_momentum, out_data.momentum_out != '0)
  `HSUF_ASSERT_NEXT(a_enter, clk, rst, in_valid && !in_stall, vld[0])
  `HSUF_ASSERT_NEXT(a_freeze, clk, rst, !en, $stable(vld))

endmodule

/* tb/helix_step_uniform_field_core_test.sv */
// ----------------------------------------------------------------------------
// Helix step core - self-checking testbench
// Drives track beats through the core under several field settings, with
// random gaps on both channels, and compares each result beat against an
// arc propagation computed here in exact fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module helix_step_uniform_field_core_test;
  import hsuf_pkg::*;

  localparam int  DRAIN_CYCLES = 130;
  localparam int  PHASE_ITEMS  = 260;
  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 20'h7FFFF;
  localparam logic [FIELD_W-1:0] FIELD_MIN = 20'h80000;

  class track_scoreboard;
    logic [FIELD_W-1:0] field;
    out_beat_t          pending_tracks[$];
    int                 errors;

    function new();
      field  = FIELD_RESET;
      errors = 0;
    endfunction

    function longint round_away(longint v, int sh);
      longint unsigned half;
      half = 64'd1 << (sh - 1);
      if (v >= 0) return longint'((unsigned'(v) + half) >> sh);
      return -longint'(((64'd0 - unsigned'(v)) + half) >> sh);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned series(longint unsigned x2, bit vers);
      longint unsigned t;
      t = UNIT_Q30;
      for (int i = 0; i < HORNER_N; i++) begin
        t = UNIT_Q30 - ((x2 * t) >> 30) / (vers ? VERS_K[i] : SIN_K[i]);
      end
      return t;
    endfunction

    function void turn_sin_cos(logic [31:0] turn, output longint s, output longint c);
      logic [2:0]      oct;
      longint unsigned r, x, x2;
      longint          sv, cv;
      oct = turn[31:29];
      r = turn[28:0];
      if (oct[0]) r = 64'h2000_0000 - r;
      x  = (r * PI_HALF_Q30) >> 30;
      x2 = (x * x) >> 30;
      sv = longint'((x * series(x2, 0)) >> 30);
      cv = longint'(UNIT_Q30) - longint'((x2 * series(x2, 1)) >> 31);
      case (oct)
        3'd0: begin s = sv;  c = cv;  end
        3'd1: begin s = cv;  c = sv;  end
        3'd2: begin s = cv;  c = -sv; end
        3'd3: begin s = sv;  c = -cv; end
        3'd4: begin s = -sv; c = -cv; end
        3'd5: begin s = -cv; c = -sv; end
        3'd6: begin s = -cv; c = sv;  end
        default: begin s = -sv; c = cv; end
      endcase
    endfunction

    function out_beat_t propagate_track(in_beat_t b);
      out_beat_t       r;
      longint          x, z, dx, dz, bf, st, g1, g2, sa, ca, sg, mx, mz;
      logic [127:0]    num, den, q;
      longint unsigned a, x2, sc, vr;
      logic [255:0]    wide;
      x  = longint'($signed(b.pos_x));
      z  = longint'($signed(b.pos_z));
      dx = longint'($signed(b.dir_x));
      dz = longint'($signed(b.dir_z));
      bf = longint'($signed(field));
      st = longint'($signed(b.step_length));
      if (b.momentum == '0) begin
        r = '{b.pos_x, b.pos_z, b.dir_x, b.dir_z, '0, 1'b1};
        return r;
      end
      num = 128'(LIGHT_NUM) * 128'(bf < 0 ? -bf : bf) * 128'(st < 0 ? -st : st);
      num = num << 30;
      den = 128'(b.momentum) * 128'(DEN_SCALE) * (128'd1 << 16);
      q = num / den;
      a = q[63:0];
      sg = ((bf < 0) != (st < 0)) ? 1 : -1;
      if (a < SMALL_LIM) begin
        x2 = (a * a) >> 30;
        sc = series(x2, 0);
        vr = series(x2, 1);
        g1 = longint'(sc);
        g2 = longint'((a * vr) >> 31);
        sa = longint'((a * sc) >> 30);
        ca = longint'(UNIT_Q30) - longint'((x2 * vr) >> 31);
      end else begin
        wide = 256'(a) * 256'(TWO_OVER_PI);
        turn_sin_cos(wide[95:64], sa, ca);
        g1 = (sa * longint'(UNIT_Q30)) / longint'(a);
        g2 = ((longint'(UNIT_Q30) - ca) * longint'(UNIT_Q30)) / longint'(a);
      end
      g2 = g2 * sg;
      sa = sa * sg;
      mx = round_away(g1 * dx + g2 * dz, RND_M);
      mz = round_away(g1 * dz - g2 * dx, RND_M);
      r.pos_x_out = 32'(clamp(x + round_away(st * mx, 16 + RND_P), -64'sh8000_0000,
                              64'sh7FFF_FFFF));
      r.pos_z_out = 32'(clamp(z + round_away(st * mz, 16 + RND_P), -64'sh8000_0000,
                              64'sh7FFF_FFFF));
      r.dir_x_out = 18'(clamp(round_away(dx * ca + sa * dz, 30), -131072, 131071));
      r.dir_z_out = 18'(clamp(round_away(dz * ca - sa * dx, 30), -131072, 131071));
      r.momentum_out = b.momentum;
      r.bad_momentum = 1'b0;
      return r;
    endfunction

    function void note_input(in_beat_t b);
      pending_tracks.push_back(propagate_track(b));
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_tracks.size() == 0) begin
        $error("result beat with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_tracks.pop_front();
      if (got.pos_x_out !== want.pos_x_out) begin
        $error("pos_x_out: expected %h, got %h", want.pos_x_out, got.pos_x_out);
        errors++;
      end
      if (got.pos_z_out !== want.pos_z_out) begin
        $error("pos_z_out: expected %h, got %h", want.pos_z_out, got.pos_z_out);
        errors++;
      end
      if (got.dir_x_out !== want.dir_x_out) begin
        $error("dir_x_out: expected %h, got %h", want.dir_x_out, got.dir_x_out);
        errors++;
      end
      if (got.dir_z_out !== want.dir_z_out) begin
        $error("dir_z_out: expected %h, got %h", want.dir_z_out, got.dir_z_out);
        errors++;
      end
      if (got.momentum_out !== want.momentum_out) begin
        $error("momentum_out: expected %h, got %h", want.momentum_out, got.momentum_out);
        errors++;
      end
      if (got.bad_momentum !== want.bad_momentum) begin
        $error("bad_momentum: expected %b, got %b", want.bad_momentum, got.bad_momentum);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [FIELD_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_beat_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_beat_t          out_data;
  bit                 quiet = 1'b0;

  track_scoreboard sb = new();

  always #6 clk = ~clk;

  helix_step_uniform_field_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [31:0] draw_magnitude();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [DIR_W-1:0] draw_dir();
    case ($urandom_range(0, 7))
      0: return 18'h10000;
      1: return 18'h30000;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] draw_pos();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
      1: return 32'h8000_0000 + $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t random_track();
    in_beat_t   b;
    logic [31:0] s;
    b.pos_x = draw_pos();
    b.pos_z = draw_pos();
    b.dir_x = draw_dir();
    b.dir_z = draw_dir();
    b.momentum = ($urandom_range(0, 19) == 0) ? 32'd0 : draw_magnitude();
    s = draw_magnitude();
    b.step_length = $urandom_range(0, 1) ? -s : s;
    return b;
  endfunction

  task automatic send_track(in_beat_t b);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_tracks.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_field(logic [FIELD_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.field = v;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_track(random_track());
    end
  endtask

  // result side: random hold per beat, checked at the accepting edge
  initial begin
    int unsigned n;
    @(posedge clk iff !rst);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_beat_t d[$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero momentum, zero step, small angle, vanishing angle
    d.push_back('{32'h0001_0000, 32'hFFFF_0000, 18'h10000, 18'h0, 32'd0, 32'h0064_0000});
    d.push_back('{32'h1234_5678, 32'h8765_4321, 18'h0B505, 18'h0B505, 32'h0001_0000, 32'd0});
    d.push_back('{32'h0, 32'h0, 18'h10000, 18'h0, 32'h0001_0000, 32'h000A_0000});
    d.push_back('{32'h0, 32'h0, 18'h0, 18'h30000, 32'hFFFF_FFFF, 32'd1});
    // growing turns, then large turns at the smallest momentum
    for (int k = 1; k <= 8; k++)
      d.push_back('{32'h0, 32'h0, 18'h10000, 18'h0, 32'h0000_4000, 32'(k) * 32'h0003_0000});
    d.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 18'h10000, 18'h30000, 32'd1, 32'h7FFF_FFFF});
    d.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 18'h30000, 18'h10000, 32'd1, 32'h8000_0000});
    // straight-line overflow into saturation
    d.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 18'h10000, 18'h30000, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF});
    d.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 18'h30000, 18'h10000, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF});
    d.push_back('{32'hFFFF_FFFF, 32'h0, 18'h3FFFF, 18'h1FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
    foreach (d[i]) send_track(d[i]);
    run_random(PHASE_ITEMS);
    drain();

    write_field('0);
    run_random(PHASE_ITEMS);
    drain();
    write_field(FIELD_MAX);
    run_random(PHASE_ITEMS);
    drain();
    write_field(FIELD_MIN);
    run_random(PHASE_ITEMS);
    drain();
    write_field(20'($urandom));
    run_random(PHASE_ITEMS);
    drain();
    write_field(FIELD_RESET);
    run_random(PHASE_ITEMS);
    drain();

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
